// ===== rtl/core/mdfr_pkg.sv =====
// Shared types, constants and reset values of the mesh duplicate filter relay unit.
`default_nettype none
package mdfr_pkg;

  localparam int RING_DEPTH  = 10;
  localparam int NUM_SOURCES = 256;

  localparam int FIELD_W    = 8;
  localparam int LIMIT_W    = 9;
  localparam int REP_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_COMMAND = 2'd3;

  localparam logic [FIELD_W-1:0] OWN_NODE_ID_RST  = 8'd1;
  localparam logic [LIMIT_W-1:0] SOURCE_LIMIT_RST = 9'd250;
  localparam logic [REP_W-1:0]   REPEAT_LIMIT_RST = 3'd5;
  localparam logic [FIELD_W-1:0] PING_COMMAND_RST = 8'd0;

  typedef enum logic [1:0] {
    VERDICT_NEW    = 2'd0,
    VERDICT_REPEAT = 2'd1,
    VERDICT_DROP   = 2'd2
  } verdict_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic prep;
    logic load_ptr;
    logic scan;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic drop_src;
    logic hit;
    logic scan_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mdfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mdfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdfr_ctrl.sv =====
// Sequencer for the duplicate filter: handshakes and datapath commands.
`default_nettype none
module mdfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mdfr_pkg::dp_cmd_t      cmd,
  input  wire mdfr_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PTR,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load_item = in_valid && in_ready;
    cmd.prep      = (state == ST_PREP);
    cmd.load_ptr  = (state == ST_PTR);
    cmd.scan      = (state == ST_SCAN);
    cmd.commit    = (state == ST_COMMIT);
    cmd.load_out  = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // New result wins over the transfer of the one it replaces
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= ST_PREP;
          end
        end
        ST_PREP:   state <= stat.drop_src ? ST_FINISH : ST_PTR;
        ST_PTR:    state <= ST_SCAN;
        ST_SCAN: begin
          if (stat.hit || stat.scan_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mdfr_dp.sv =====
// Datapath: item and config registers, ring store, pointer store, scan and result.
`default_nettype none
module mdfr_dp #(
  parameter int RING_DEPTH  = mdfr_pkg::RING_DEPTH,
  parameter int NUM_SOURCES = mdfr_pkg::NUM_SOURCES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mdfr_pkg::dp_cmd_t                   cmd,
  output mdfr_pkg::dp_stat_t                       stat,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]        source_id,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]        packet_count,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]        hops_left,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]        dest_id,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]        command,
  input  wire logic                                cfg_we,
  input  wire logic [mdfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mdfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [1:0]                               verdict,
  output logic                                     deliver,
  output logic                                     relay,
  output logic [mdfr_pkg::FIELD_W-1:0]             relay_hops,
  output logic                                     ping_for_me
);

  localparam int FW    = mdfr_pkg::FIELD_W;
  localparam int RW    = mdfr_pkg::REP_W;
  localparam int EA_W  = $clog2(NUM_SOURCES * RING_DEPTH);
  localparam int SRC_W = $clog2(NUM_SOURCES);
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int ENT_W = FW + RW;
  localparam int PTR_W = IDX_W + 1;

  // Config registers
  logic [FW-1:0]                own_id;
  logic [mdfr_pkg::LIMIT_W-1:0] src_limit;
  logic [RW-1:0]                rep_limit;
  logic [FW-1:0]                ping_cmd;

  // Item registers
  logic [FW-1:0] src, cnt, hops, dest, cmd_code;

  // Scan state
  logic [EA_W-1:0]  base;
  logic [IDX_W-1:0] ptr;
  logic             full;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic [EA_W-1:0]  pend_addr;
  logic             hit_flag;
  logic [RW-1:0]    hit_rep;
  logic [EA_W-1:0]  hit_addr;
  mdfr_pkg::verdict_t vd;

  // Pointer store valid bits
  logic [NUM_SOURCES-1:0] ptr_vld;

  logic [SRC_W-1:0] src_idx;
  logic [EA_W-1:0]  ent_raddr;
  logic [ENT_W-1:0] ent_rdata;
  logic             ent_we;
  logic [EA_W-1:0]  ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [PTR_W-1:0] ptr_rdata;
  logic             ptr_we;
  logic [PTR_W-1:0] ptr_wdata;
  logic             ptr_last;
  logic             more;
  logic             match;
  logic             rep_ok;
  logic             keep;
  logic             do_relay;

  assign src_idx   = src[SRC_W-1:0];
  assign ent_raddr = base + EA_W'(idx);
  assign more      = idx < limit;
  assign match     = pend && (ent_rdata[ENT_W-1:RW] == cnt);
  assign ptr_last  = (ptr == IDX_W'(RING_DEPTH - 1));
  assign rep_ok    = hit_rep < rep_limit;

  assign stat.drop_src  = ({1'b0, src} >= src_limit)
                       || ({1'b0, src} >= mdfr_pkg::LIMIT_W'(NUM_SOURCES))
                       || (src == own_id);
  assign stat.hit       = match;
  assign stat.scan_done = !pend && !more;

  // Commit write-back: bump repeat count on a hit below the repeat limit, new entry on a miss
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = base + EA_W'(ptr);
    ent_wdata = {cnt, RW'(1)};
    ptr_we    = 1'b0;
    ptr_wdata = {full | ptr_last, ptr_last ? IDX_W'(0) : IDX_W'(ptr + 1'b1)};
    if (cmd.commit) begin
      if (hit_flag) begin
        ent_we    = rep_ok;
        ent_waddr = hit_addr;
        ent_wdata = {cnt, RW'(hit_rep + 1'b1)};
      end else begin
        ent_we = 1'b1;
        ptr_we = 1'b1;
      end
    end
  end

  mdfr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SOURCES * RING_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  mdfr_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_SOURCES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (src_idx),
    .wdata (ptr_wdata),
    .raddr (src_idx),
    .rdata (ptr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id    <= mdfr_pkg::OWN_NODE_ID_RST;
      src_limit <= mdfr_pkg::SOURCE_LIMIT_RST;
      rep_limit <= mdfr_pkg::REPEAT_LIMIT_RST;
      ping_cmd  <= mdfr_pkg::PING_COMMAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdfr_pkg::CFG_OWN_NODE_ID:  own_id    <= cfg_data[FW-1:0];
        mdfr_pkg::CFG_SOURCE_LIMIT: src_limit <= cfg_data;
        mdfr_pkg::CFG_REPEAT_LIMIT: rep_limit <= cfg_data[RW-1:0];
        mdfr_pkg::CFG_PING_COMMAND: ping_cmd  <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_vld <= '0;
    end else if (ptr_we) begin
      ptr_vld[src_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      hit_flag <= 1'b0;
      idx      <= '0;
    end else begin
      if (cmd.load_ptr) begin
        pend     <= 1'b0;
        hit_flag <= 1'b0;
        idx      <= '0;
      end else if (cmd.scan) begin
        if (match) begin
          hit_flag <= 1'b1;
          pend     <= 1'b0;
        end else if (more) begin
          pend <= 1'b1;
          idx  <= idx + 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      src      <= source_id;
      cnt      <= packet_count;
      hops     <= hops_left;
      dest     <= dest_id;
      cmd_code <= command;
    end
    if (cmd.prep) begin
      base <= EA_W'(src * RING_DEPTH);
      vd   <= mdfr_pkg::VERDICT_DROP;
    end
    if (cmd.load_ptr) begin
      ptr   <= ptr_vld[src_idx] ? ptr_rdata[IDX_W-1:0] : '0;
      full  <= ptr_vld[src_idx] && ptr_rdata[PTR_W-1];
      limit <= (ptr_vld[src_idx] && ptr_rdata[PTR_W-1]) ? CNT_W'(RING_DEPTH)
             : (ptr_vld[src_idx] ? CNT_W'(ptr_rdata[IDX_W-1:0]) : '0);
    end
    if (cmd.scan && !match && more) begin
      pend_addr <= ent_raddr;
    end
    if (cmd.scan && match) begin
      hit_rep  <= ent_rdata[RW-1:0];
      hit_addr <= pend_addr;
    end
    if (cmd.commit) begin
      vd <= !hit_flag ? mdfr_pkg::VERDICT_NEW
          : (rep_ok ? mdfr_pkg::VERDICT_REPEAT : mdfr_pkg::VERDICT_DROP);
    end
  end

  // Result register
  assign keep     = (vd != mdfr_pkg::VERDICT_DROP);
  assign do_relay = keep && (hops != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      verdict     <= vd;
      deliver     <= keep;
      relay       <= do_relay;
      relay_hops  <= do_relay ? FW'(hops - 1'b1) : '0;
      ping_for_me <= keep && (cmd_code == ping_cmd) && (dest == own_id);
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (idx <= limit))
    else $error("scan index ran past ring fill");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !hit_flag) |-> (CNT_W'(ptr) < CNT_W'(RING_DEPTH)))
    else $error("ring pointer out of range at miss commit");

  a_hit_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && match) |=> hit_flag)
    else $error("scan hit not recorded");

  a_vld_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !hit_flag) |=> ptr_vld[src_idx])
    else $error("pointer entry not marked valid after miss");

endmodule
`default_nettype wire

// ===== rtl/core/mesh_duplicate_filter_relay_unit.sv =====
// Top level of the mesh duplicate filter relay unit: sequencer plus datapath.
// Flow: a frame dropped for its source goes from PREP straight to the result
//   register; otherwise PREP, pointer fetch, ring scan (one entry per cycle)
//   and write-back run before the result is loaded.
// Frames: one at a time; the next is taken only once this result is loaded
//   into the output register. Reset: config to defaults, all stores read as
//   empty at once (per-source pointer valid bits).
`default_nettype none
module mesh_duplicate_filter_relay_unit #(
  parameter int RING_DEPTH  = mdfr_pkg::RING_DEPTH,
  parameter int NUM_SOURCES = mdfr_pkg::NUM_SOURCES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Frame header input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]    source_id,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]    packet_count,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]    hops_left,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]    dest_id,
  input  wire logic [mdfr_pkg::FIELD_W-1:0]    command,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           verdict,
  output logic                                 deliver,
  output logic                                 relay,
  output logic [mdfr_pkg::FIELD_W-1:0]         relay_hops,
  output logic                                 ping_for_me,
  // Config write port
  input  wire logic                            cfg_we,
  input  wire logic [mdfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  mdfr_pkg::dp_cmd_t  cmd;
  mdfr_pkg::dp_stat_t stat;

  // Sequencer: takes one input transfer, walks the datapath, then parks the
  // result in the output register. A new frame may be taken while the
  // previous result still waits for its output transfer.
  mdfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: per-source ring of recent packet counts with repeat counts,
  // per-source ring pointer with a full flag, and the result register.
  mdfr_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .source_id    (source_id),
    .packet_count (packet_count),
    .hops_left    (hops_left),
    .dest_id      (dest_id),
    .command      (command),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .verdict      (verdict),
    .deliver      (deliver),
    .relay        (relay),
    .relay_hops   (relay_hops),
    .ping_for_me  (ping_for_me)
  );

endmodule
`default_nettype wire
